// File: hdl/aer_pkg.sv
`timescale 1ns / 1ps
// Package for the single-entry ARP cache with aging and re-request.
// Holds the word types, code constants and control structs. No dependencies.
package aer_pkg;

  // Command codes on the input word.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_LEARN   = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;

  // Action codes on the result word.
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_HIT     = 2'd1;
  localparam logic [1:0] ACT_MISS    = 2'd2;
  localparam logic [1:0] ACT_REFRESH = 2'd3;

  // Entry modes.
  localparam logic [1:0] MODE_FREE    = 2'd0;
  localparam logic [1:0] MODE_VALID   = 2'd1;
  localparam logic [1:0] MODE_PENDING = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMER_PERIOD    = 2'd0;
  localparam logic [1:0] REG_VALID_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_PENDING_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_MAX_RETRIES     = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] TIMER_PERIOD_RST    = 16'd1;
  localparam logic [7:0]  VALID_TIMEOUT_RST   = 8'd5;
  localparam logic [7:0]  PENDING_TIMEOUT_RST = 8'd1;
  localparam logic [7:0]  MAX_RETRIES_RST     = 8'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] found_mac;
    logic [31:0] request_ip;
    logic [1:0]  entry_status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cfg_write;
  } dp_cmd_t;

  // Controller states: result register empty or holding a word.
  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } ctrl_state_t;

endpackage

// File: hdl/aer_ctrl.sv
`timescale 1ns / 1ps
// Controller for the ARP entry block: tracks the result register and the handshakes.
// Depends on aer_pkg.
module aer_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output aer_pkg::dp_cmd_t dp_cmd
);
  import aer_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs. A new word is taken whenever the
  // result register is empty or its word leaves in this cycle.
  always_comb begin
    out_valid        = (state == ST_FULL);
    in_stall         = (state == ST_FULL) && out_stall;
    cfg_ready        = 1'b1;
    dp_cmd.load      = in_valid && !in_stall;
    dp_cmd.cfg_write = cfg_valid;
    state_next       = state;
    case (state)
      ST_EMPTY: begin
        if (dp_cmd.load) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (!out_stall && !dp_cmd.load) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

endmodule

// File: hdl/aer_dp.sv
`timescale 1ns / 1ps
// Datapath for the ARP entry block: configuration, entry state, aging and result register.
// Depends on aer_pkg.
module aer_dp (
  input  logic              clk,
  input  logic              rst,
  input  aer_pkg::dp_cmd_t  dp_cmd,
  input  aer_pkg::in_word_t in_data,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output aer_pkg::out_word_t out_data
);
  import aer_pkg::*;

  logic [15:0] timer_period;
  logic [7:0]  valid_timeout;
  logic [7:0]  pending_timeout;
  logic [7:0]  max_retries;

  logic [1:0]  entry_mode;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic [7:0]  countdown;
  logic [7:0]  retries_left;
  logic [15:0] prescaler;

  logic [1:0]  entry_mode_next;
  logic [31:0] entry_ip_next;
  logic [47:0] entry_mac_next;
  logic [7:0]  countdown_next;
  logic [7:0]  retries_left_next;
  logic [15:0] prescaler_next;
  out_word_t   result;
  logic [7:0]  count_dec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period    <= TIMER_PERIOD_RST;
      valid_timeout   <= VALID_TIMEOUT_RST;
      pending_timeout <= PENDING_TIMEOUT_RST;
      max_retries     <= MAX_RETRIES_RST;
    end else if (dp_cmd.cfg_write) begin
      case (cfg_index)
        REG_TIMER_PERIOD:    timer_period    <= cfg_data;
        REG_VALID_TIMEOUT:   valid_timeout   <= cfg_data[7:0];
        REG_PENDING_TIMEOUT: pending_timeout <= cfg_data[7:0];
        REG_MAX_RETRIES:     max_retries     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Step logic: one word updates the entry and forms its result.
  always_comb begin
    entry_mode_next   = entry_mode;
    entry_ip_next     = entry_ip;
    entry_mac_next    = entry_mac;
    countdown_next    = countdown;
    retries_left_next = retries_left;
    prescaler_next    = prescaler;
    count_dec         = countdown - 8'd1;
    result            = '0;
    case (in_data.cmd)
      CMD_TICK: begin
        if (prescaler >= timer_period) begin
          // Aging step fires.
          prescaler_next = '0;
          if (entry_mode == MODE_VALID) begin
            countdown_next = count_dec;
            if (count_dec == 8'd0) begin
              entry_mode_next   = MODE_PENDING;
              countdown_next    = pending_timeout;
              result.action     = ACT_REFRESH;
              result.request_ip = entry_ip;
            end
          end else if (entry_mode == MODE_PENDING) begin
            countdown_next = count_dec;
            if (count_dec == 8'd0) begin
              if (retries_left == 8'd0) begin
                entry_mode_next = MODE_FREE;
              end else begin
                retries_left_next = retries_left - 8'd1;
                countdown_next    = pending_timeout;
                result.action     = ACT_REFRESH;
                result.request_ip = entry_ip;
              end
            end
          end
        end else begin
          prescaler_next = prescaler + 16'd1;
        end
      end
      CMD_LEARN: begin
        entry_ip_next     = in_data.ip_addr;
        entry_mac_next    = in_data.hw_addr;
        entry_mode_next   = MODE_VALID;
        countdown_next    = valid_timeout;
        retries_left_next = max_retries;
      end
      CMD_RESOLVE: begin
        if (entry_mode == MODE_VALID && entry_ip == in_data.ip_addr) begin
          result.action    = ACT_HIT;
          result.found_mac = entry_mac;
        end else begin
          result.action     = ACT_MISS;
          result.request_ip = in_data.ip_addr;
        end
      end
      default: ;
    endcase
    result.entry_status = entry_mode_next;
  end

  // Entry state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_mode   <= MODE_FREE;
      entry_ip     <= '0;
      entry_mac    <= '0;
      countdown    <= '0;
      retries_left <= '0;
      prescaler    <= '0;
    end else if (dp_cmd.load) begin
      entry_mode   <= entry_mode_next;
      entry_ip     <= entry_ip_next;
      entry_mac    <= entry_mac_next;
      countdown    <= countdown_next;
      retries_left <= retries_left_next;
      prescaler    <= prescaler_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      out_data <= result;
    end
  end

endmodule

// File: hdl/arp_entry_refresh_fsm_top.sv
`timescale 1ns / 1ps
// Top level of the single-entry ARP cache with aging and re-request.
// Depends on aer_pkg, aer_ctrl and aer_dp.
//
// Usage:
// - Input channel (in_valid, in_stall, in_data) carries one word per command:
//   a tick, a learn of an IP and MAC pair, or a resolve of an IP.
// - Output channel (out_valid, out_stall, out_data) returns exactly one result
//   word per input word, in order.
// - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   timer period and the timeouts; cfg_ready is always high. Write only while idle.
// - The result word is registered and appears in the cycle after acceptance.
// - Throughput is one word per cycle while the receiver does not stall; the whole step
//   (compares and counter updates) is done in the single stage in front of the result register.
// - When the receiver stalls, the result word holds and in_stall rises, so no
//   further word is taken until the held word leaves.
// - Reset (synchronous, active high) frees the entry, clears the counters and
//   prescaler, empties the result register and restores the configuration defaults.
module arp_entry_refresh_fsm_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aer_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aer_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import aer_pkg::*;

  dp_cmd_t dp_cmd;

  // Controller.
  aer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .dp_cmd    (dp_cmd)
  );

  // Datapath.
  aer_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// File: hdl/aer_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the ARP entry block, bound to the top level.
// Depends on aer_pkg and arp_entry_refresh_fsm_top.
module aer_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input aer_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input aer_pkg::out_word_t out_data
);
  import aer_pkg::*;

  // A stalled result word stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Every accepted word yields a result word in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("no result word after an accepted word");

  // The input is held off only by a held and stalled result word.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result word");

  // A learn leaves the entry valid.
  a_learn_valid: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.cmd == CMD_LEARN
    |=> out_data.entry_status == MODE_VALID)
    else $error("learn did not leave the entry valid");

  // A hit comes only from a valid entry, and only a hit carries a MAC.
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.action == ACT_HIT ? out_data.entry_status == MODE_VALID
                                              : out_data.found_mac == '0))
    else $error("hit on an entry that is not valid, or MAC on a non-hit");

endmodule

bind arp_entry_refresh_fsm_top aer_checker u_aer_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/tb_arp_entry_refresh_fsm_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for arp_entry_refresh_fsm_top, the one-entry ARP cache with aging.
// It predicts every result word from its own copy of the cache state, and depends on aer_pkg.
module tb_arp_entry_refresh_fsm_top;
  import aer_pkg::*;

  // Clock, reset and the driven side of every channel.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  in_word_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_TIMER_PERIOD;
  logic [15:0] cfg_data = '0;

  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;
  logic      cfg_ready;

  // Idling percentages for the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          err_count = 0;

  // Expected result words, oldest first.
  out_word_t predicted_replies[$];

  // Predicted configuration of the cache.
  logic [15:0] cfg_period  = TIMER_PERIOD_RST;
  logic [7:0]  cfg_valid_to = VALID_TIMEOUT_RST;
  logic [7:0]  cfg_pend_to  = PENDING_TIMEOUT_RST;
  logic [7:0]  cfg_retries  = MAX_RETRIES_RST;

  // Predicted state of the cache entry and the aging prescaler.
  logic [1:0]  ent_mode    = MODE_FREE;
  logic [31:0] ent_ip      = '0;
  logic [47:0] ent_mac     = '0;
  logic [7:0]  ent_count   = '0;
  logic [7:0]  ent_retries = '0;
  logic [15:0] presc       = '0;

  arp_entry_refresh_fsm_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result word of one command and moves the predicted state on.
  function automatic out_word_t arp_step(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.cmd)
      CMD_TICK: begin
        if (presc >= cfg_period) begin
          presc = '0;
          // One aging step of the entry; a free entry is left alone.
          if (ent_mode == MODE_VALID) begin
            ent_count = ent_count - 8'd1;
            if (ent_count == 8'd0) begin
              ent_mode  = MODE_PENDING;
              ent_count = cfg_pend_to;
              r.action  = ACT_REFRESH;
            end
          end else if (ent_mode == MODE_PENDING) begin
            ent_count = ent_count - 8'd1;
            if (ent_count == 8'd0) begin
              if (ent_retries == 8'd0) begin
                ent_mode = MODE_FREE;
              end else begin
                ent_retries = ent_retries - 8'd1;
                ent_count   = cfg_pend_to;
                r.action    = ACT_REFRESH;
              end
            end
          end
          if (r.action == ACT_REFRESH) r.request_ip = ent_ip;
        end else begin
          presc = presc + 16'd1;
        end
      end
      CMD_LEARN: begin
        ent_ip      = w.ip_addr;
        ent_mac     = w.hw_addr;
        ent_mode    = MODE_VALID;
        ent_count   = cfg_valid_to;
        ent_retries = cfg_retries;
      end
      CMD_RESOLVE: begin
        if (ent_mode == MODE_VALID && ent_ip == w.ip_addr) begin
          r.action    = ACT_HIT;
          r.found_mac = ent_mac;
        end else begin
          r.action     = ACT_MISS;
          r.request_ip = w.ip_addr;
        end
      end
      default: ;
    endcase
    r.entry_status = ent_mode;
    return r;
  endfunction

  // Sends one word after a random gap and records its predicted result.
  // Valid is left high on return, so back-to-back words need no extra edge.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted_replies.push_back(arp_step(w));
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [31:0] ip, logic [47:0] mac);
    in_word_t w;
    w.cmd     = cmd;
    w.ip_addr = ip;
    w.hw_addr = mac;
    send_word(w);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_cmd(CMD_TICK, $urandom, {16'($urandom), 32'($urandom)});
  endtask

  // Stops sending and waits until every predicted result word has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after the last write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIMER_PERIOD:    cfg_period   = val;
      REG_VALID_TIMEOUT:   cfg_valid_to = val[7:0];
      REG_PENDING_TIMEOUT: cfg_pend_to  = val[7:0];
      REG_MAX_RETRIES:     cfg_retries  = val[7:0];
      default: ;
    endcase
  endtask

  // Rewrites all four registers; only called once the cache is idle.
  task automatic configure(logic [15:0] period, logic [7:0] valid_to,
                           logic [7:0] pend_to, logic [7:0] retries);
    drain();
    write_reg(REG_TIMER_PERIOD, period);
    write_reg(REG_VALID_TIMEOUT, {8'd0, valid_to});
    write_reg(REG_PENDING_TIMEOUT, {8'd0, pend_to});
    write_reg(REG_MAX_RETRIES, {8'd0, retries});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hits, misses and the whole aging life of an entry under the reset settings.
  task automatic test_reset_defaults();
    send_cmd(CMD_RESOLVE, 32'd0, 48'd0);
    send_cmd(2'd3, '1, '1);
    send_cmd(CMD_LEARN, '1, '1);
    send_cmd(CMD_RESOLVE, '1, 48'd0);
    send_cmd(CMD_RESOLVE, 32'd0, '1);
    send_cmd(CMD_LEARN, 32'd0, 48'd0);
    send_cmd(CMD_RESOLVE, 32'd0, '1);
    send_cmd(CMD_LEARN, 32'hC0A8_0001, 48'h0123_4567_89AB);
    send_cmd(CMD_RESOLVE, 32'hC0A8_0001, 48'd0);
    // Five aging steps at two ticks each bring the refresh request.
    send_ticks(10);
    // A pending entry does not answer a resolve, even for its own address.
    send_cmd(CMD_RESOLVE, 32'hC0A8_0001, 48'd0);
    // Three re-requests, then the entry is freed.
    send_ticks(8);
    send_cmd(CMD_RESOLVE, 32'hC0A8_0001, 48'd0);
  endtask

  // Period zero with spent retries, then a period lowered below the count.
  task automatic test_period_edges();
    configure(16'd0, 8'd1, 8'd2, 8'd0);
    send_cmd(CMD_LEARN, 32'h0A00_0002, 48'hFEDC_BA98_7654);
    send_ticks(4);
    configure(16'hFFFF, 8'd255, 8'd255, 8'd255);
    send_cmd(CMD_LEARN, 32'h0A00_0003, 48'h0000_0000_0001);
    send_ticks(6);
    configure(16'd2, 8'd255, 8'd255, 8'd255);
    send_ticks(2);
    send_cmd(CMD_RESOLVE, 32'h0A00_0003, 48'd0);
  endtask

  // Countdowns loaded with zero wrap and expire after 256 aging steps.
  task automatic test_zero_timeout();
    configure(16'd0, 8'd0, 8'd0, 8'd1);
    send_cmd(CMD_LEARN, 32'h7F00_0001, 48'h5555_AAAA_5555);
    send_ticks(256 * 3 + 1);
  endtask

  // Random traffic, mostly ticks and lookups of the stored address.
  task automatic test_random(int unsigned idle, int unsigned stall, int n);
    in_word_t    w;
    int unsigned pick;
    drain();
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0)
        configure(16'($urandom_range(3)), 8'($urandom_range(6, 1)),
                  8'($urandom_range(3, 1)), 8'($urandom_range(3)));
      pick      = $urandom_range(99);
      w.ip_addr = $urandom;
      w.hw_addr = {16'($urandom), 32'($urandom)};
      if (pick < 50) begin
        w.cmd = CMD_TICK;
      end else if (pick < 62) begin
        w.cmd = CMD_LEARN;
      end else if (pick < 95) begin
        w.cmd = CMD_RESOLVE;
        if ($urandom_range(99) < 70) w.ip_addr = ent_ip;
      end else begin
        w.cmd = 2'd3;
      end
      send_word(w);
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Compares every accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_replies
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: result word with none expected: %h", $time, out_data);
        err_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (out_data.action !== want.action) begin
          $display("%0t: action expected %h, got %h", $time, want.action, out_data.action);
          err_count++;
        end
        if (out_data.found_mac !== want.found_mac) begin
          $display("%0t: found_mac expected %h, got %h", $time, want.found_mac,
                   out_data.found_mac);
          err_count++;
        end
        if (out_data.request_ip !== want.request_ip) begin
          $display("%0t: request_ip expected %h, got %h", $time, want.request_ip,
                   out_data.request_ip);
          err_count++;
        end
        if (out_data.entry_status !== want.entry_status) begin
          $display("%0t: entry_status expected %h, got %h", $time, want.entry_status,
                   out_data.entry_status);
          err_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_period_edges();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    test_zero_timeout();
    test_random(0, 0, 225);
    test_random(71, 0, 225);
    test_random(0, 71, 225);
    test_random(20, 20, 225);
    drain();
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: arp_entry_refresh_fsm_top.f
hdl/aer_pkg.sv
hdl/aer_ctrl.sv
hdl/aer_dp.sv
hdl/arp_entry_refresh_fsm_top.sv
hdl/aer_checker.sv
tb/tb_arp_entry_refresh_fsm_top.sv
